// ----- rtl/rvie_pkg.sv -----
// Shared types, opcodes and constants of the register VM instruction executor.
package rvie_pkg;

   localparam int MemBytes     = 65536;
   localparam int ProgramBytes = 65536;
   localparam int AddrW        = $clog2(MemBytes);
   localparam int BankAddrW    = AddrW - 2;
   localparam int QueueDepth   = 2;

   localparam logic [7:0] OP_NOP = 8'h00;
   localparam logic [7:0] OP_ADD = 8'h01;
   localparam logic [7:0] OP_SUB = 8'h02;
   localparam logic [7:0] OP_AND = 8'h03;
   localparam logic [7:0] OP_OR  = 8'h04;
   localparam logic [7:0] OP_XOR = 8'h05;
   localparam logic [7:0] OP_NOT = 8'h06;
   localparam logic [7:0] OP_LSH = 8'h07;
   localparam logic [7:0] OP_ASH = 8'h08;
   localparam logic [7:0] OP_TCU = 8'h09;
   localparam logic [7:0] OP_TCS = 8'h0A;
   localparam logic [7:0] OP_SET = 8'h0B;
   localparam logic [7:0] OP_MOV = 8'h0C;
   localparam logic [7:0] OP_LDW = 8'h0D;
   localparam logic [7:0] OP_STW = 8'h0E;
   localparam logic [7:0] OP_LDB = 8'h0F;
   localparam logic [7:0] OP_STB = 8'h10;

   localparam logic [1:0] ST_EXEC = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   typedef struct packed {
      logic [7:0] opcode;
      logic [4:0] ra;
      logic [4:0] rb;
      logic [4:0] rc;
      logic [7:0] fb;
      logic [7:0] fc;
   } instr_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_pc;
      logic [14:0] bad_line;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
   } result_type;

endpackage

// ----- rtl/rvie_ram.sv -----
// Generic single-port RAM with registered read.
module rvie_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

// ----- rtl/rvie_front.sv -----
// Front end: accepts instruction items, decodes fields, feeds a short queue.
module rvie_front import rvie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   output logic        q_valid,
   input  logic        q_pop,
   output instr_type   q_instr
);
   localparam int PtrW = $clog2(QueueDepth);

   instr_type             slot_ff [QueueDepth];
   logic [PtrW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]         count_ff;
   logic                  push;
   instr_type             dec;

   always_comb begin
      dec.opcode = req_tdata[7:0];
      dec.ra     = req_tdata[12:8];
      dec.fb     = req_tdata[23:16];
      dec.rb     = req_tdata[20:16];
      dec.fc     = req_tdata[31:24];
      dec.rc     = req_tdata[28:24];
   end

   assign req_tready = (count_ff != (PtrW+1)'(QueueDepth));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_instr    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (!(q_pop && !q_valid)) else $error("pop from empty queue");
         assert (count_ff <= (PtrW+1)'(QueueDepth)) else $error("queue overflow");
      end
   end
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (PtrW+1)'(QueueDepth)) |-> !push) else $error("push when full");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("count mismatch");
endmodule

// ----- rtl/rvie_back.sv -----
// Back end: register file, data memory banks and execution of queued instructions.
module rvie_back import rvie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [16:0] program_size,
   input  logic        q_valid,
   output logic        q_pop,
   input  instr_type   q_instr,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output result_type  rsp_res,
   output logic        idle
);
   // Pipeline: stage 1 reads memory banks (registered), stage 2 finishes and commits.
   // Register operands are read in stage 1, with a bypass from stage 2.
   typedef enum logic [1:0] {
      CL_RUN, CL_BAD, CL_DONE
   } class_type;

   logic [31:0]     regs_ff [32];
   logic            halted_ff;

   // stage 1 -> 2
   logic            s2_valid_ff;
   instr_type       s2_instr_ff;
   logic [31:0]     s2_b_ff, s2_c_ff, s2_a_ff, s2_pc_ff;
   logic [1:0]      s2_off_ff;
   logic [AddrW-1:0] s2_addr_ff;
   class_type       s2_class_ff;
   logic [7:0]      bank_rdata [4];

   // output register
   logic            out_valid_ff;
   result_type      out_ff;

   logic            s2_adv;
   logic            s1_adv;
   logic            s1_go;
   logic            out_free;

   // memory clearing pass after reset
   logic                 clr_ff;
   logic [BankAddrW-1:0] clr_addr_ff;

   // stage 2 results feed bypass and halt
   logic            s2_wr;
   logic [4:0]      s2_widx;
   logic [31:0]     s2_wval;
   logic [31:0]     s2_newpc;
   result_type      s2_res;
   logic            s2_halt;
   logic            s2_st;
   logic [31:0]     s2_st_addr;

   // stage 1 read with bypass
   function automatic logic [31:0] rd(input logic [4:0] i, input logic [31:0] f,
                                      input logic byp, input logic [4:0] bi,
                                      input logic [31:0] bv, input logic [31:0] bpc,
                                      input logic padv);
      logic [31:0] v;
      v = f;
      if (padv) begin
         if (byp && bi == i) v = bv;
         // pc update lands after the register write
         if (i == 5'd0) v = bpc;
      end
      return v;
   endfunction

   logic [31:0] s1_b, s1_c, s1_a, s1_pc;
   logic        s1_halt;
   logic [16:0] psize;
   logic        s1_done;
   logic [31:0] s1_addr;
   logic        s2_commit;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign s2_adv    = s2_valid_ff && out_free;
   assign s2_commit = s2_adv && (s2_class_ff == CL_RUN);
   // Stage 1 moves when stage 2 empties or advances.
   assign s1_adv    = q_valid && (!s2_valid_ff || s2_adv);
   assign q_pop     = s1_go;

   assign psize = (program_size > 17'(ProgramBytes)) ? 17'(ProgramBytes) : program_size;

   always_comb begin
      s1_pc   = rd(5'd0, regs_ff[0], s2_wr, s2_widx, s2_wval, s2_newpc, s2_commit);
      s1_b    = rd(q_instr.rb, regs_ff[q_instr.rb], s2_wr, s2_widx, s2_wval, s2_newpc,
                   s2_commit);
      s1_c    = rd(q_instr.rc, regs_ff[q_instr.rc], s2_wr, s2_widx, s2_wval, s2_newpc,
                   s2_commit);
      s1_a    = rd(q_instr.ra, regs_ff[q_instr.ra], s2_wr, s2_widx, s2_wval, s2_newpc,
                   s2_commit);
      s1_halt = halted_ff || (s2_adv && s2_halt);
      s1_done = s1_halt || (s1_pc >= {15'd0, psize});
      s1_addr = s1_b;
      if (q_instr.opcode == OP_STW || q_instr.opcode == OP_STB) s1_addr = s1_a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) clr_ff <= 1'b0;
      end
   end

   // Memory: four byte banks, byte-interleaved by address low bits.
   logic [BankAddrW-1:0] bank_addr [4];
   logic                 bank_we [4];
   logic [7:0]           bank_wdata [4];

   always_comb begin
      logic [AddrW-1:0] base;
      logic [AddrW-1:0] sa;
      logic [AddrW-1:0] ba;
      // a held stage 2 keeps re-reading its own address
      base = s1_go ? s1_addr[AddrW-1:0] : s2_addr_ff;
      sa   = s2_st_addr[AddrW-1:0];
      for (int k = 0; k < 4; k++) begin
         // bank k holds bytes with addr[1:0]==k
         ba = base + AddrW'((k - int'(base[1:0]) + 4) % 4);
         bank_addr[k]  = ba[AddrW-1:2];
         bank_we[k]    = 1'b0;
         bank_wdata[k] = '0;
         if (s2_commit && s2_st) begin
            ba = sa + AddrW'((k - int'(sa[1:0]) + 4) % 4);
            bank_addr[k]  = ba[AddrW-1:2];
            bank_wdata[k] = s2_b_ff[8*((k - int'(sa[1:0]) + 4) % 4) +: 8];
            bank_we[k]    = (s2_instr_ff.opcode == OP_STW) || (sa[1:0] == 2'(k));
         end
         if (clr_ff) begin
            bank_addr[k]  = clr_addr_ff;
            bank_we[k]    = 1'b1;
            bank_wdata[k] = '0;
         end
      end
   end

   // A store commit in stage 2 collides with a stage-1 read: stall stage 1.
   logic st_block;
   assign st_block = s2_valid_ff && s2_st && (s2_class_ff == CL_RUN);

   for (genvar g = 0; g < 4; g++) begin : g_bank
      rvie_ram #(.Width(8), .Depth(MemBytes / 4)) u_bank (
         .clock (clock),
         .we    (bank_we[g]),
         .addr  (bank_addr[g]),
         .wdata (bank_wdata[g]),
         .rdata (bank_rdata[g])
      );
   end

   assign s1_go = s1_adv && !st_block && !clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_go) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_instr_ff <= q_instr;
         s2_b_ff     <= s1_b;
         s2_c_ff     <= s1_c;
         s2_a_ff     <= s1_a;
         s2_pc_ff    <= s1_pc;
         s2_off_ff   <= s1_addr[1:0];
         s2_addr_ff  <= s1_addr[AddrW-1:0];
         if (s1_done) begin
            s2_class_ff <= CL_DONE;
         end else if (q_instr.opcode > OP_STB) begin
            s2_class_ff <= CL_BAD;
         end else begin
            s2_class_ff <= CL_RUN;
         end
      end
   end

   // Stage 2 execute.
   always_comb begin
      logic [31:0] b, c, v, n, ldw;
      logic        w;
      logic [1:0]  o;
      b = s2_b_ff;
      c = s2_c_ff;
      v = '0;
      w = 1'b1;
      n = 32'd0 - c;
      o = s2_off_ff;
      for (int k = 0; k < 4; k++) begin
         ldw[8*k +: 8] = bank_rdata[2'(int'(o) + k)];
      end
      s2_st      = (s2_instr_ff.opcode == OP_STW) || (s2_instr_ff.opcode == OP_STB);
      s2_st_addr = s2_a_ff;
      case (s2_instr_ff.opcode)
         OP_NOP: w = 1'b0;
         OP_ADD: v = b + c;
         OP_SUB: v = b - c;
         OP_AND: v = b & c;
         OP_OR:  v = b | c;
         OP_XOR: v = b ^ c;
         OP_NOT: v = ~b;
         OP_LSH, OP_ASH: begin
            if (c == '0) begin
               w = 1'b0;
            end else if (!c[31]) begin
               v = (c >= 32'd32) ? 32'd0 : (b << c[4:0]);
            end else if (s2_instr_ff.opcode == OP_ASH) begin
               v = (n >= 32'd32) ? {32{b[31]}} : 32'($signed(b) >>> n[4:0]);
            end else begin
               v = (n >= 32'd32) ? 32'd0 : (b >> n[4:0]);
            end
         end
         OP_TCU: v = (b < c) ? '1 : '0;
         OP_TCS: v = ($signed(b) < $signed(c)) ? '1 : '0;
         OP_SET: v = {{16{s2_instr_ff.fc[7]}}, s2_instr_ff.fc, s2_instr_ff.fb};
         OP_MOV: v = b;
         OP_LDW: v = ldw;
         OP_LDB: v = {s2_a_ff[31:8], ldw[7:0]};
         OP_STW, OP_STB: w = 1'b0;
         default: w = 1'b0;
      endcase
      s2_wr   = w && (s2_class_ff == CL_RUN);
      s2_widx = s2_instr_ff.ra;
      s2_wval = v;
      s2_newpc = ((s2_wr && s2_widx == 5'd0) ? v : s2_pc_ff) + 32'd4;
      s2_halt = (s2_class_ff == CL_BAD);
      s2_res  = '0;
      case (s2_class_ff)
         CL_RUN: begin
            s2_res.status  = ST_EXEC;
            s2_res.next_pc = s2_newpc;
            if (s2_wr) begin
               s2_res.reg_written = 1'b1;
               s2_res.reg_index   = s2_widx;
               s2_res.reg_value   = v;
            end
         end
         CL_BAD: begin
            s2_res.status   = ST_BAD;
            s2_res.next_pc  = s2_pc_ff;
            s2_res.bad_line = 15'(s2_pc_ff[31:2] + 30'd1);
         end
         default: begin
            s2_res.status  = ST_DONE;
            s2_res.next_pc = s2_pc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs_ff[i] <= '0;
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_commit) begin
            if (s2_wr) regs_ff[s2_widx] <= s2_wval;
            regs_ff[0] <= s2_newpc;
         end
         if (s2_adv && s2_halt) halted_ff <= 1'b1;
         if (s2_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) out_ff <= s2_res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_res    = out_ff;
   assign idle       = !s2_valid_ff && !q_valid;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halt cleared");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(out_ff)) else $error("result changed");
   a_no_commit_halted: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && s2_valid_ff && $past(halted_ff)) |-> (s2_class_ff == CL_DONE))
      else $error("executed while halted");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !q_pop) else $error("item taken during memory clear");
endmodule

// ----- rtl/register_vm_instruction_executor.sv -----
// Top level of the register VM instruction executor.
//
// Usage: each req_ item is one 4-byte instruction (opcode, field_a, field_b,
// field_c). Each accepted item gives exactly one rsp_ item in order: status,
// next_pc, bad_line and the register write it made.
// csr_ writes program_size; write it only while no item is in flight.
// Path: the queue feeds the read stage, then the execute stage, then the output
// register that drives rsp_tvalid.
// Throughput: one item per cycle when rsp_ is not stalled, except stores: a
// store holds the memory port of the four byte banks until it commits, so the
// item behind it waits.
// Reset clears registers, the halt flag and program_size, then runs a
// clearing pass that zeroes the data memory; items are queued during the
// pass but execute only after it. A stalled rsp_ holds its item; the
// 2-entry queue and the execute stage keep accepting until they fill.
// An invalid opcode halts the block until reset; later items report finished.
module register_vm_instruction_executor import rvie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // opcode, field_a, field_b, field_c
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // status, next_pc, bad_line, reg_written, reg_index,
                                   // reg_value, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);
   logic        q_valid, q_pop, idle;
   instr_type   q_instr;
   result_type  res;
   logic [16:0] psize_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         psize_ff <= csr_data;
      end
   end

   rvie_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_instr    (q_instr)
   );

   rvie_back u_back (
      .clock        (clock),
      .reset        (reset),
      .program_size (psize_ff),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_instr      (q_instr),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_res      (res),
      .idle         (idle)
   );

   assign rsp_tdata = {1'b0, res.reg_value, res.reg_index, res.reg_written,
                       res.bad_line, res.next_pc, res.status};

   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> idle) else $error("config while busy");
   a_bad_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.status == ST_EXEC) |-> (res.bad_line == '0))
      else $error("bad_line on executed item");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res.status != 2'd3)) else $error("bad status");
endmodule

// ----- bench/rvie_checker.sv -----
// Checker: tracks the executor state, predicts each response and compares it.
`timescale 1ns / 1ps
module rvie_checker import rvie_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [16:0] csr_data,
   output int          fail_count,
   output int          pending,
   output logic [31:0] model_pc
);

   logic [31:0] regs [32];
   logic [7:0]  mem [MemBytes];
   logic        halted;
   logic [16:0] prog_size;
   result_type  expected_q [$];

   assign model_pc = regs[0];

   function automatic logic [31:0] shifted(logic [31:0] v, logic [31:0] cnt, logic arith);
      logic [31:0] fill;
      logic [31:0] n;
      fill = (arith && v[31]) ? 32'hFFFF_FFFF : 32'h0;
      if (!cnt[31]) begin
         return (cnt >= 32) ? 32'h0 : v << cnt;
      end
      n = -cnt;
      if (n >= 32) return fill;
      return arith ? 32'($signed(v) >>> n) : v >> n;
   endfunction

   task automatic execute(input logic [31:0] insn);
      logic [7:0]  op;
      logic [4:0]  ra, rb, rc;
      logic [7:0]  fb, fc;
      logic [31:0] b, c, v, pc, adr;
      logic [16:0] lim;
      logic        wr;
      result_type  r;
      op = insn[7:0];
      ra = insn[12:8];
      fb = insn[23:16];
      fc = insn[31:24];
      rb = fb[4:0];
      rc = fc[4:0];
      b  = regs[rb];
      c  = regs[rc];
      pc = regs[0];
      lim = (prog_size > ProgramBytes) ? 17'(ProgramBytes) : prog_size;
      v  = '0;
      wr = 1'b1;
      r  = '0;
      if (halted || pc >= lim) begin
         r.status  = ST_DONE;
         r.next_pc = pc;
      end else if (op > OP_STB) begin
         halted     = 1'b1;
         r.status   = ST_BAD;
         r.next_pc  = pc;
         r.bad_line = 15'(pc / 4 + 1);
      end else begin
         case (op)
            OP_NOP: wr = 1'b0;
            OP_ADD: v = b + c;
            OP_SUB: v = b - c;
            OP_AND: v = b & c;
            OP_OR:  v = b | c;
            OP_XOR: v = b ^ c;
            OP_NOT: v = ~b;
            OP_LSH, OP_ASH: begin
               if (c == 0) wr = 1'b0;
               else v = shifted(b, c, op == OP_ASH);
            end
            OP_TCU: v = (b < c) ? 32'hFFFF_FFFF : 32'h0;
            OP_TCS: v = ($signed(b) < $signed(c)) ? 32'hFFFF_FFFF : 32'h0;
            OP_SET: v = {{16{fc[7]}}, fc, fb};
            OP_MOV: v = b;
            OP_LDW: begin
               for (int k = 3; k >= 0; k--)
                  v = {v[23:0], mem[(b + k) % MemBytes]};
            end
            OP_STW: begin
               adr = regs[ra];
               for (int k = 0; k < 4; k++)
                  mem[(adr + k) % MemBytes] = b[8*k +: 8];
               wr = 1'b0;
            end
            OP_LDB: v = {regs[ra][31:8], mem[b % MemBytes]};
            default: begin
               mem[regs[ra] % MemBytes] = b[7:0];
               wr = 1'b0;
            end
         endcase
         if (wr) begin
            regs[ra]      = v;
            r.reg_written = 1'b1;
            r.reg_index   = ra;
            r.reg_value   = v;
         end
         regs[0]   = regs[0] + 4;
         r.status  = ST_EXEC;
         r.next_pc = regs[0];
      end
      expected_q.push_back(r);
   endtask

   task automatic compare(input logic [87:0] d);
      result_type got, want;
      got.status      = d[1:0];
      got.next_pc     = d[33:2];
      got.bad_line    = d[48:34];
      got.reg_written = d[49];
      got.reg_index   = d[54:50];
      got.reg_value   = d[86:55];
      if (expected_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected response item: %p", got);
         return;
      end
      want = expected_q.pop_front();
      if (got !== want || d[87] !== 1'b0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("mismatch: expected %p, got %p", want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) regs[i] = '0;
         halted     = 1'b0;
         prog_size  = '0;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare(rsp_tdata);
         if (req_tvalid && req_tready) execute(req_tdata);
         if (csr_valid && csr_ready) prog_size = csr_data;
      end
      pending = expected_q.size();
   end

   initial begin
      for (int i = 0; i < MemBytes; i++) mem[i] = 8'h00;
   end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: clock, reset, instruction stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_top;
   import rvie_pkg::*;

   localparam int CycleLimit = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_data = '0;

   int          fail_count, pending, cycles;
   logic [31:0] model_pc;
   int          tx_idle_pct = 0, rx_stall_pct = 0, hold_cycles = 0;
   logic        hold_req = 1'b0, hold_seen = 1'b0;

   always #4 clock = ~clock;

   register_vm_instruction_executor dut (.*);

   rvie_checker chk (.*);

   // receiver back-pressure; a toggle of hold_req starts a long hold
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen   <= hold_req;
         hold_cycles <= 40;
         rsp_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge with req_tvalid still high
   task automatic send(input logic [7:0] op, input logic [7:0] fa,
                       input logic [7:0] fb, input logic [7:0] fc);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {fc, fb, fa, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_size(input logic [16:0] v);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [7:0] op, fa, fb, fc;
      op = 8'($urandom_range(16));
      if ($urandom_range(99) < 20) op = OP_SET;
      fa = {3'($urandom), 5'($urandom_range(31, 1))};
      fb = 8'($urandom);
      case ($urandom_range(3))
         0: fc = 8'h00;
         1: fc = 8'hFF;
         default: fc = 8'($urandom);
      endcase
      send(op, fa, fb, fc);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // program size zero: everything reports finished
      send(OP_NOP, 8'h00, 8'h00, 8'h00);
      send(OP_ADD, 8'h01, 8'h02, 8'h03);
      write_size(17'h1FFFF);

      send(OP_SET, 8'h01, 8'hFF, 8'h7F);
      send(OP_SET, 8'h02, 8'h00, 8'h80);
      send(OP_SET, 8'h03, 8'h01, 8'h00);
      send(OP_SET, 8'h04, 8'hFF, 8'hFF);
      send(OP_SET, 8'h05, 8'h21, 8'h00);
      send(OP_SET, 8'h06, 8'hDF, 8'hFF);
      send(OP_ADD, 8'h07, 8'h02, 8'h04);
      send(OP_SUB, 8'h08, 8'h03, 8'h02);
      send(OP_AND, 8'h09, 8'h01, 8'h02);
      send(OP_OR,  8'h0A, 8'h01, 8'h02);
      send(OP_XOR, 8'h0B, 8'h04, 8'h01);
      send(OP_NOT, 8'h0C, 8'h03, 8'h00);
      send(OP_LSH, 8'h0D, 8'h01, 8'h03);
      send(OP_LSH, 8'h0D, 8'h02, 8'h04);   // negative count: right
      send(OP_LSH, 8'h0E, 8'h01, 8'h05);   // count past 31
      send(OP_LSH, 8'hEE, 8'hE1, 8'hEF);   // zero count writes nothing
      send(OP_ASH, 8'h10, 8'h02, 8'h04);
      send(OP_ASH, 8'h10, 8'h02, 8'h06);   // saturates to sign bits
      send(OP_TCU, 8'h12, 8'h03, 8'h04);
      send(OP_TCS, 8'h13, 8'h04, 8'h03);
      send(OP_TCS, 8'h13, 8'h03, 8'h04);
      send(OP_MOV, 8'h14, 8'h02, 8'h00);
      send(OP_STW, 8'h04, 8'h01, 8'h00);   // address wraps around memory top
      send(OP_LDW, 8'h15, 8'h04, 8'h00);
      send(OP_STB, 8'h03, 8'h02, 8'h00);
      send(OP_LDB, 8'h16, 8'h03, 8'h00);
      send(OP_SET, 8'h00, 8'h00, 8'h01);   // jump: pc written directly

      // small program: two more instructions then finished
      write_size(17'(model_pc + 8));
      repeat (4) send_random();
      write_size(17'd65536);

      for (int ph = 0; ph < 4; ph++) begin
         tx_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 24 : 0;
         rx_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 24 : 0;
         for (int i = 0; i < 104; i++) begin
            if (ph == 0 && i == 30) hold_req = ~hold_req;
            send_random();
         end
         settle();
      end

      // invalid opcode halts; later items report finished
      send(8'h11, 8'hFF, 8'hFF, 8'hFF);
      send(8'hFF, 8'h00, 8'h00, 8'h00);
      send(OP_NOP, 8'h00, 8'h00, 8'h00);
      settle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- register_vm_instruction_executor.f -----
rtl/rvie_pkg.sv
rtl/rvie_ram.sv
rtl/rvie_front.sv
rtl/rvie_back.sv
rtl/register_vm_instruction_executor.sv
bench/rvie_checker.sv
bench/tb_top.sv
